// ===== hdl/ext2_inode_locator_macros.svh =====
// Assertion helpers shared by the locator modules.
`ifndef EXT2_INODE_LOCATOR_MACROS_SVH
`define EXT2_INODE_LOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define EIL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EIL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EIL_ASSERT(lbl, clk, rstn, prop, msg)
`define EIL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hdl/eil_pkg.sv =====
package eil_pkg;

  localparam int unsigned MAX_GROUPS_DEF = 1024;
  localparam int unsigned DATA_W = 32;

  // Command codes.
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_LOCATE = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_INODE_TOTAL      = 3'd0;
  localparam logic [2:0] REG_INODES_PER_GROUP = 3'd1;
  localparam logic [2:0] REG_INODE_BYTES      = 3'd2;
  localparam logic [2:0] REG_LOG_BLOCK_SIZE   = 3'd3;
  localparam logic [2:0] REG_BLOCK_TOTAL      = 3'd4;
  localparam logic [2:0] REG_FIRST_DATA_BLOCK = 3'd5;
  localparam logic [2:0] REG_BLOCKS_PER_GROUP = 3'd6;

  localparam logic [31:0] IPG_RESET = 32'd2048;
  localparam logic [31:0] BPG_RESET = 32'd8192;
  localparam logic [15:0] DEFAULT_INODE_BYTES = 16'd128;
  localparam logic [2:0]  MAX_LOG_BLOCK = 3'd6;
  localparam logic [5:0]  BASE_SHIFT = 6'd10;

  // Side information that travels with an item through the divider.
  typedef struct packed {
    logic        cmd;
    logic        bad;
    logic [9:0]  slot;
    logic [31:0] start;
  } eil_tag_t;

endpackage

// ===== hdl/eil_div_pipe.sv =====
`include "ext2_inode_locator_macros.svh"

module eil_div_pipe #(
  parameter int unsigned W = eil_pkg::DATA_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  input  eil_pkg::eil_tag_t in_tag,
  output logic              out_valid,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder,
  output eil_pkg::eil_tag_t out_tag
);
  import eil_pkg::*;

  logic              v_r   [0:W];
  logic [W-1:0]      q_r   [0:W];
  logic [W-1:0]      rem_r [0:W];
  eil_tag_t          tag_r [0:W];
  logic [W:0]        trial [0:W-1];
  logic              ge    [0:W-1];

  // One restoring step per stage: bring in the next dividend bit and subtract.
  always_comb begin
    for (int k = 0; k < W; k++) begin
      trial[k] = {rem_r[k], q_r[k][W-1]};
      ge[k]    = trial[k] >= {1'b0, divisor};
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= W; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int k = 0; k < W; k++) v_r[k+1] <= v_r[k];
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (en) begin
      q_r[0]   <= dividend;
      rem_r[0] <= '0;
      tag_r[0] <= in_tag;
      for (int k = 0; k < W; k++) begin
        q_r[k+1]   <= {q_r[k][W-2:0], ge[k]};
        rem_r[k+1] <= ge[k] ? W'(trial[k] - {1'b0, divisor}) : trial[k][W-1:0];
        tag_r[k+1] <= tag_r[k];
      end
    end
  end

  assign out_valid = v_r[W];
  assign quotient  = q_r[W];
  assign remainder = rem_r[W];
  assign out_tag   = tag_r[W];

  `EIL_ASSERT(a_rem_below_divisor, clk, rst_n, out_valid && divisor != '0 |-> remainder < divisor, "divider remainder not below divisor")
  `EIL_ASSERT(a_zero_divisor, clk, rst_n, out_valid && divisor == '0 |-> quotient == '1, "zero divisor must give all-ones quotient")

endmodule

// ===== hdl/eil_desc_mem.sv =====
module eil_desc_mem #(
  parameter int unsigned AW = 10
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);
  import eil_pkg::*;

  logic [31:0] mem [0:(1 << AW)-1];
  logic [31:0] rdata_r;

  // Descriptor write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, held while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/ext2_inode_locator.sv =====
// ext2 inode locator.
// Input channel (in_valid / in_stall) carries one command beat: a load writes
// the inode-table start block of group in_group_slot into the descriptor
// memory, a locate turns in_inode_number into a disk block and byte offset.
// Every beat gives exactly one result beat on the out_ channel, in order.
// Configuration is written through cfg_valid / cfg_ready / cfg_index /
// cfg_data; the user must do so only while no beat is in flight, which the
// block itself does not enforce; cfg_ready is always high.
// An accepted input beat is captured at the accepting edge, then passes 32
// stages of the pipelined restoring divider (one quotient bit per stage), one
// multiply and descriptor-read stage, and the output register to out_valid.
// Throughput is one beat per cycle unless stalled; the divider pipeline sets latency.
// Loads write the descriptor memory at the same stage where locates read it,
// so beats see the table in arrival order.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; nothing is dropped.
// Reset clears all valid bits and loads the configuration reset values;
// descriptor contents are undefined until loaded.
`include "ext2_inode_locator_macros.svh"

module ext2_inode_locator #(
  parameter int unsigned MAX_GROUPS = eil_pkg::MAX_GROUPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_inode_number,
  input  logic [9:0]  in_group_slot,
  input  logic [31:0] in_table_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_block_address,
  output logic [15:0] out_byte_offset,
  output logic [9:0]  out_group_number,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import eil_pkg::*;

  localparam int unsigned AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;

  // Configuration registers.
  logic [31:0] inode_total_r, ipg_r, block_total_r, fdb_r, bpg_r;
  logic [15:0] inode_bytes_r;
  logic [2:0]  log_bs_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inode_total_r <= '0;
      ipg_r         <= IPG_RESET;
      inode_bytes_r <= '0;
      log_bs_r      <= '0;
      block_total_r <= '0;
      fdb_r         <= '0;
      bpg_r         <= BPG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INODE_TOTAL:      inode_total_r <= cfg_data;
        REG_INODES_PER_GROUP: ipg_r         <= cfg_data;
        REG_INODE_BYTES:      inode_bytes_r <= cfg_data[15:0];
        REG_LOG_BLOCK_SIZE:   log_bs_r      <= cfg_data[2:0];
        REG_BLOCK_TOTAL:      block_total_r <= cfg_data;
        REG_FIRST_DATA_BLOCK: fdb_r         <= cfg_data;
        REG_BLOCKS_PER_GROUP: bpg_r         <= cfg_data;
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being taken.
  logic out_valid_r;
  logic en;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Input check and divider.
  eil_tag_t    in_tag;
  logic        d_valid;
  logic [31:0] d_quo, d_rem;
  eil_tag_t    d_tag;

  always_comb begin
    in_tag.cmd   = in_command;
    in_tag.bad   = (in_inode_number == '0) || (in_inode_number > inode_total_r);
    in_tag.slot  = in_group_slot;
    in_tag.start = in_table_start;
  end

  eil_div_pipe #(.W(DATA_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid && !in_stall),
    .dividend  (in_inode_number - 32'd1),
    .divisor   (ipg_r),
    .in_tag    (in_tag),
    .out_valid (d_valid),
    .quotient  (d_quo),
    .remainder (d_rem),
    .out_tag   (d_tag)
  );

  // Multiply and descriptor access stage.
  logic        m_valid_r, m_cmd_r, m_bad_r, m_hi_r;
  logic [31:0] m_grp_r;
  logic [63:0] m_gprod_r;
  logic [47:0] m_pos_r;
  logic [15:0] isize;
  logic        mem_we;
  logic [31:0] mem_q;

  assign isize  = (inode_bytes_r == '0) ? DEFAULT_INODE_BYTES : inode_bytes_r;
  assign mem_we = en && d_valid && (d_tag.cmd == CMD_LOAD) &&
                  ({22'd0, d_tag.slot} < 32'(MAX_GROUPS));

  eil_desc_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .en    (en),
    .we    (mem_we),
    .waddr (AW'(d_tag.slot)),
    .wdata (d_tag.start),
    .raddr (AW'(d_quo)),
    .rdata (mem_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (en) begin
      m_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_cmd_r   <= d_tag.cmd;
      m_bad_r   <= d_tag.bad;
      m_hi_r    <= d_quo >= 32'(MAX_GROUPS);
      m_grp_r   <= d_quo;
      m_gprod_r <= {32'd0, d_quo} * {32'd0, bpg_r};
      m_pos_r   <= {16'd0, d_rem} * {32'd0, isize};
    end
  end

  // Range check, address and offset into the output register.
  logic        no_groups, in_range;
  logic [32:0] span;
  logic [5:0]  shift;
  logic [47:0] mask;
  logic [1:0]  status_nxt;
  logic [31:0] blk_nxt;
  logic [15:0] off_nxt;
  logic [9:0]  grp_nxt;

  always_comb begin
    no_groups = (bpg_r == '0) || (fdb_r > block_total_r);
    span      = {1'b0, block_total_r} - {1'b0, fdb_r};
    in_range  = !no_groups && !m_hi_r && (m_gprod_r < {31'd0, span});
    shift     = BASE_SHIFT + {3'd0, (log_bs_r > MAX_LOG_BLOCK) ? MAX_LOG_BLOCK : log_bs_r};
    mask      = (48'd1 << shift) - 48'd1;
    status_nxt = ST_OK;
    blk_nxt    = '0;
    off_nxt    = '0;
    grp_nxt    = '0;
    if (m_cmd_r == CMD_LOCATE) begin
      if (m_bad_r) begin
        status_nxt = ST_BAD;
      end else if (!in_range) begin
        status_nxt = ST_RANGE;
        grp_nxt    = m_grp_r[9:0];
      end else begin
        blk_nxt = mem_q + 32'(m_pos_r >> shift);
        off_nxt = 16'(m_pos_r & mask);
        grp_nxt = m_grp_r[9:0];
      end
    end
  end

  logic [1:0]  status_r;
  logic [31:0] blk_r;
  logic [15:0] off_r;
  logic [9:0]  grp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= m_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status_r <= status_nxt;
      blk_r    <= blk_nxt;
      off_r    <= off_nxt;
      grp_r    <= grp_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_block_address = blk_r;
  assign out_byte_offset   = off_r;
  assign out_group_number  = grp_r;

  `EIL_ASSERT(a_hold_on_stall, clk, rst_n, out_valid && out_stall |-> in_stall, "input taken while result blocked")
  `EIL_ASSERT(a_range_zero, clk, rst_n, out_valid && out_status != ST_OK |-> out_block_address == '0 && out_byte_offset == '0, "error result carries an address")
  `EIL_ASSERT(a_no_load_when_bad_slot, clk, rst_n, mem_we |-> d_tag.cmd == CMD_LOAD && d_valid, "descriptor written without a load")

endmodule

// ===== tb/sv/ext2_inode_locator_tb.sv =====
`timescale 1ns / 1ps

module ext2_inode_locator_tb;
  import eil_pkg::*;

  localparam int unsigned GROUP_SLOTS = MAX_GROUPS_DEF;
  localparam int unsigned DRAIN_CYCLES = 40;

  // One command beat waiting to go in, and one predicted location.
  typedef struct {
    logic        cmd;
    logic [31:0] num;
    logic [9:0]  slot;
    logic [31:0] start;
  } command_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] blk;
    logic [15:0] off;
    logic [9:0]  grp;
  } location_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = CMD_LOAD;
  logic [31:0] in_inode_number = '0;
  logic [9:0]  in_group_slot = '0;
  logic [31:0] in_table_start = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_block_address;
  logic [15:0] out_byte_offset;
  logic [9:0]  out_group_number;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ext2_inode_locator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_inode_number   (in_inode_number),
    .in_group_slot     (in_group_slot),
    .in_table_start    (in_table_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_block_address (out_block_address),
    .out_byte_offset   (out_byte_offset),
    .out_group_number  (out_group_number),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the configuration and of the descriptor table.
  logic [31:0] sh_inode_total = 32'd0;
  logic [31:0] sh_ipg = IPG_RESET;
  logic [15:0] sh_inode_bytes = 16'd0;
  logic [2:0]  sh_log = 3'd0;
  logic [31:0] sh_block_total = 32'd0;
  logic [31:0] sh_first_data = 32'd0;
  logic [31:0] sh_bpg = BPG_RESET;
  logic [31:0] table_mirror [GROUP_SLOTS];

  command_t  pending_cmds[$];
  location_t expected_locs[$];

  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  bit   calm_phase = 1'b0;
  int   hold_requests = 0;
  int   hold_served = 0;
  int   mismatches = 0;
  int   n_ok = 0, n_bad = 0, n_range = 0, n_load = 0;

  function automatic logic [63:0] groups_spanned();
    logic [63:0] span;
    if (sh_bpg == 0 || sh_first_data > sh_block_total) return 64'd0;
    span = {32'd0, sh_block_total} - {32'd0, sh_first_data};
    return (span + sh_bpg - 64'd1) / sh_bpg;
  endfunction

  // Where the inode of a locate beat lives, given the current shadow state.
  function automatic location_t locate_inode(command_t c);
    location_t   r;
    logic [63:0] n1, grp, idx, size, pos;
    int          sh;
    r = '{default: '0};
    if (c.cmd == CMD_LOAD) return r;
    if (c.num == 0 || c.num > sh_inode_total) begin
      r.status = ST_BAD;
      return r;
    end
    n1 = {32'd0, c.num} - 64'd1;
    if (sh_ipg == 0) begin
      grp = 64'hFFFF_FFFF;
      idx = n1;
    end else begin
      grp = n1 / sh_ipg;
      idx = n1 % sh_ipg;
    end
    r.grp = grp[9:0];
    if (grp >= groups_spanned() || grp >= GROUP_SLOTS) begin
      r.status = ST_RANGE;
      return r;
    end
    size = (sh_inode_bytes == 0) ? 64'(DEFAULT_INODE_BYTES) : 64'(sh_inode_bytes);
    pos = idx * size;
    sh = BASE_SHIFT + ((sh_log > MAX_LOG_BLOCK) ? MAX_LOG_BLOCK : sh_log);
    r.status = ST_OK;
    r.blk = table_mirror[grp[9:0]] + 32'(pos >> sh);
    r.off = 16'(pos & ((64'd1 << sh) - 64'd1));
    return r;
  endfunction

  function automatic int draw_wait();
    if (calm_phase || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Input driver: presents queued beats with random gaps between them.
  int send_gap = 0;
  always @(negedge clk) begin
    command_t c;
    logic     nv;
    if (rst_n) begin
      nv = in_valid;
      if (in_valid && in_taken) nv = 1'b0;
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_command <= c.cmd;
          in_inode_number <= c.num;
          in_group_slot <= c.slot;
          in_table_start <= c.start;
          nv = 1'b1;
          send_gap = draw_wait();
        end
      end
      in_valid <= nv;
    end
  end

  // Result receiver: random stalls per beat, plus long holds on request.
  int stall_left = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_served != hold_requests) begin
        hold_left = 400;
        hold_served++;
      end
      if (hold_left > 0) hold_left--;
      if (out_taken) stall_left = draw_wait();
      else if (stall_left > 0) stall_left--;
      out_stall <= (hold_left > 0) || (stall_left > 0);
    end
  end

  // Monitor: predicts on each accepted command and checks each result beat.
  always @(posedge clk) begin
    command_t  c;
    location_t e;
    in_taken <= in_valid && !in_stall;
    out_taken <= out_valid && !out_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_locs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat at %0t", $realtime);
      end else begin
        e = expected_locs.pop_front();
        if (out_status !== e.status || out_block_address !== e.blk ||
            out_byte_offset !== e.off || out_group_number !== e.grp) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: exp st=%0d blk=%h off=%h grp=%0d",
                     $realtime, e.status, e.blk, e.off, e.grp);
            $display("  got st=%0d blk=%h off=%h grp=%0d", out_status,
                     out_block_address, out_byte_offset, out_group_number);
          end
        end
        case (e.status)
          ST_OK: n_ok++;
          ST_BAD: n_bad++;
          default: n_range++;
        endcase
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      c.cmd = in_command;
      c.num = in_inode_number;
      c.slot = in_group_slot;
      c.start = in_table_start;
      if (c.cmd == CMD_LOAD) begin
        table_mirror[c.slot] = c.start;
        n_load++;
      end
      expected_locs.push_back(locate_inode(c));
    end
  end

  task automatic wait_idle();
    while (pending_cmds.size() > 0 || in_valid || expected_locs.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_INODE_TOTAL:      sh_inode_total = val;
      REG_INODES_PER_GROUP: sh_ipg = val;
      REG_INODE_BYTES:      sh_inode_bytes = val[15:0];
      REG_LOG_BLOCK_SIZE:   sh_log = val[2:0];
      REG_BLOCK_TOTAL:      sh_block_total = val;
      REG_FIRST_DATA_BLOCK: sh_first_data = val;
      default:              sh_bpg = val;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_layout(logic [31:0] it, logic [31:0] ipg, logic [15:0] ib,
                            logic [2:0] lg, logic [31:0] bt, logic [31:0] fdb,
                            logic [31:0] bpg);
    wait_idle();
    write_reg(REG_INODE_TOTAL, it);
    write_reg(REG_INODES_PER_GROUP, ipg);
    write_reg(REG_INODE_BYTES, {16'd0, ib});
    write_reg(REG_LOG_BLOCK_SIZE, {29'd0, lg});
    write_reg(REG_BLOCK_TOTAL, bt);
    write_reg(REG_FIRST_DATA_BLOCK, fdb);
    write_reg(REG_BLOCKS_PER_GROUP, bpg);
  endtask

  task automatic push_load(logic [9:0] slot, logic [31:0] start);
    command_t c;
    c.cmd = CMD_LOAD;
    c.num = $urandom();
    c.slot = slot;
    c.start = start;
    pending_cmds.push_back(c);
  endtask

  task automatic push_locate(logic [31:0] num);
    command_t c;
    c.cmd = CMD_LOCATE;
    c.num = num;
    c.slot = 10'($urandom_range(0, GROUP_SLOTS - 1));
    c.start = $urandom();
    pending_cmds.push_back(c);
  endtask

  // Inode numbers mostly inside the populated groups, some at the edges.
  function automatic logic [31:0] pick_inode();
    logic [63:0] gc, cap;
    int          r;
    gc = groups_spanned();
    if (gc > GROUP_SLOTS) gc = 64'(GROUP_SLOTS);
    cap = (sh_ipg == 0) ? 64'd1 : {32'd0, sh_ipg} * gc;
    if (cap > {32'd0, sh_inode_total}) cap = {32'd0, sh_inode_total};
    if (cap == 0) cap = 64'd1;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, cap[31:0]);
    if (r == 6) return sh_inode_total + $urandom_range(0, 2) - 1;
    if (r == 7) return $urandom_range(0, 3);
    return $urandom();
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 4) == 0)
        push_load(10'($urandom_range(0, GROUP_SLOTS - 1)), $urandom());
      else push_locate(pick_inode());
    end
  endtask

  initial begin
    logic [31:0] ipg, bpg, fdb;
    logic [63:0] it64, bt64;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Fill every descriptor entry so no locate reads an unwritten one.
    push_load(10'd0, 32'd0);
    push_load(10'd1, 32'hFFFF_FFFF);
    for (int s = 2; s < GROUP_SLOTS; s++) push_load(10'(s), $urandom());
    // With reset values the inode count is zero, so every number is rejected.
    push_locate(32'd0);
    push_locate(32'd1);
    push_locate(32'hFFFF_FFFF);

    // Small file system: 100 groups of 8 inodes, more inodes than groups hold.
    set_layout(32'd960, 32'd8, 16'd0, 3'd0, 32'd6401, 32'd1, 32'd64);
    push_locate(32'd0);
    push_locate(32'd1);
    push_locate(32'd8);
    push_locate(32'd9);
    push_locate(32'd800);
    push_locate(32'd801);
    push_locate(32'd960);
    push_locate(32'd961);
    push_locate(32'hFFFF_FFFF);
    push_load(10'd99, 32'hFFFF_FFFF);
    push_locate(32'd793);
    random_items(100);
    // Pause the sender until everything is back, then go on.
    wait_idle();
    random_items(100);

    // Huge group count: groups beyond the descriptor store are rejected.
    set_layout(32'hFFFF_FFFF, 32'd1000, 16'd256, 3'd2, 32'hFFFF_FFFF, 32'd0, 32'd1);
    push_load(10'd1023, 32'hFFFF_FF00);
    push_locate(32'd1024000);
    push_locate(32'd1024001);
    calm_phase = 1'b1;
    hold_requests++;
    random_items(150);
    wait_idle();
    calm_phase = 1'b0;

    // Zero inodes per group.
    set_layout(32'd5000, 32'd0, 16'd1, 3'd1, 32'd6401, 32'd1, 32'd64);
    random_items(60);
    // Zero blocks per group.
    set_layout(32'd960, 32'd8, 16'd128, 3'd3, 32'd6401, 32'd1, 32'd0);
    random_items(60);
    // First data block past the block total.
    set_layout(32'd960, 32'd8, 16'd0, 3'd4, 32'd5, 32'hFFFF_FFFF, 32'd64);
    random_items(60);
    // All extremes: one giant group, largest inodes, log above its limit.
    set_layout(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 3'd7, 32'hFFFF_FFFF, 32'd0, 32'd1);
    push_locate(32'hFFFF_FFFF);
    push_locate(32'hFFFF_FFFE);
    random_items(100);

    // Random layouts, some with more groups than the store holds.
    for (int p = 0; p < 3; p++) begin
      ipg = $urandom_range(1, 4096);
      bpg = $urandom_range(1, 9000);
      fdb = $urandom_range(0, 3);
      bt64 = {32'd0, fdb} + {32'd0, bpg} * $urandom_range(1, 1100);
      it64 = {32'd0, ipg} * $urandom_range(1, 1100);
      if (bt64 > 64'hFFFF_FFFF) bt64 = 64'hFFFF_FFFF;
      if (it64 > 64'hFFFF_FFFF) it64 = 64'hFFFF_FFFF;
      set_layout(it64[31:0], ipg, 16'($urandom_range(0, 1024)), 3'($urandom_range(0, 7)),
                 bt64[31:0], fdb, bpg);
      random_items(30);
    end

    wait_idle();
    $display("Covered %0d loads and %0d locates: %0d found, %0d bad numbers, %0d out of range.",
             n_load, n_ok + n_bad + n_range - n_load, n_ok - n_load, n_bad, n_range);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("Timeout with %0d results outstanding", expected_locs.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
